@@ design/i4dot_pkg.sv @@
// Shared types and constants for the int8 x int4 group dot-product row core.
// No dependencies; used by every module of the block.
package i4dot_pkg;

	localparam int SCALE_FRACTION_BITS = 12;
	localparam int NIBBLE_W    = 4;
	localparam int ACT_W       = 8;
	localparam int WBYTE_W     = 8;
	localparam int SCALE_W     = 16;
	localparam int PART_W      = 13;
	localparam int GSUM_W      = 20;
	localparam int ACC_W       = 48;
	localparam int PROD1_W     = GSUM_W + SCALE_W;
	localparam int PROD2_W     = PROD1_W + SCALE_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified item on its way from front to back
	typedef struct packed {
		logic signed [PART_W-1:0]  partial;
		logic signed [SCALE_W-1:0] act_scale;
		logic signed [SCALE_W-1:0] weight_scale;
		logic                      closes;
		logic                      row_end;
	} item_t;

endpackage

@@ design/i4dot_front.sv @@
// Front end: accepts items, forms the two nibble products and classifies
// the item (group close, row end). Depends on i4dot_pkg.
module i4dot_front import i4dot_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [ACT_W-1:0]   act_low,
	input  logic signed [ACT_W-1:0]   act_high,
	input  logic [WBYTE_W-1:0]        weight_byte,
	input  logic signed [SCALE_W-1:0] act_scale,
	input  logic signed [SCALE_W-1:0] weight_scale,
	input  logic                      group_end,
	input  logic                      row_end,
	output logic                      q_push,
	output item_t                     q_data,
	input  logic                      q_full
);

	logic signed [NIBBLE_W-1:0] w_lo;
	logic signed [NIBBLE_W-1:0] w_hi;
	logic signed [PART_W-1:0]   p_lo;
	logic signed [PART_W-1:0]   p_hi;
	logic                       valid_q;
	item_t                      item_q;
	logic                       accept;

	assign w_lo = $signed(weight_byte[NIBBLE_W-1:0]);
	assign w_hi = $signed(weight_byte[2*NIBBLE_W-1:NIBBLE_W]);
	assign p_lo = PART_W'(act_low) * PART_W'(w_lo);
	assign p_hi = PART_W'(act_high) * PART_W'(w_hi);

	assign q_push = valid_q & ~q_full;
	assign full   = valid_q & q_full;
	assign accept = push & ~full;
	assign q_data = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (q_push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.partial      <= p_lo + p_hi;
			item_q.act_scale    <= act_scale;
			item_q.weight_scale <= weight_scale;
			item_q.closes       <= group_end | row_end;
			item_q.row_end      <= row_end;
		end
	end

endmodule

@@ design/i4dot_queue.sv @@
// Short item queue between front and back.
// Depends on i4dot_pkg for item_t and depth.
module i4dot_queue import i4dot_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_push,
	input  item_t wr_data,
	output logic  q_full,
	input  logic  q_pop,
	output item_t rd_data,
	output logic  q_empty
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (q_push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !q_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/i4dot_back.sv @@
// Back end: group sum, two scale multiplies, saturating row accumulator and
// the result register. Depends on i4dot_pkg.
module i4dot_back import i4dot_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  item_t                   q_data,
	input  logic                    q_empty,
	output logic                    q_pop,
	input  logic                    pop,
	output logic                    empty,
	output logic signed [ACC_W-1:0] row_value,
	output logic                    saturated
);

	localparam logic signed [GSUM_W-1:0] GSUM_MAX = {1'b0, {(GSUM_W-1){1'b1}}};
	localparam logic signed [GSUM_W-1:0] GSUM_MIN = {1'b1, {(GSUM_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

	logic                        stall;

	// group sum stage
	logic signed [GSUM_W-1:0]    gs_q;
	logic                        grp_clip_q;
	logic signed [GSUM_W:0]      gs_sum;
	logic                        gs_ovf;
	logic signed [GSUM_W-1:0]    gs_new;

	// multiply stages
	logic                        v_s1, v_s2, v_s3;
	logic signed [GSUM_W-1:0]    gsum_s1;
	logic signed [SCALE_W-1:0]   sa_s1;
	logic signed [SCALE_W-1:0]   sw_s1, sw_s2;
	logic                        row_end_s1, row_end_s2, row_end_s3;
	logic                        clip_s1, clip_s2, clip_s3;
	logic signed [PROD1_W-1:0]   prod1_s2;
	logic signed [PROD2_W-1:0]   prod2_s3;

	// accumulate stage
	logic signed [ACC_W-1:0]     acc_q;
	logic                        clip_q;
	logic signed [PROD2_W-1:0]   term;
	logic signed [ACC_W:0]       acc_sum;
	logic                        acc_ovf;
	logic signed [ACC_W-1:0]     acc_new;
	logic                        acc_fire;
	logic                        out_valid_q;

	assign stall = v_s3 & row_end_s3 & out_valid_q & ~pop;
	assign q_pop = ~q_empty & ~stall;

	assign gs_sum = (GSUM_W+1)'(gs_q) + (GSUM_W+1)'(q_data.partial);
	assign gs_ovf = gs_sum[GSUM_W] ^ gs_sum[GSUM_W-1];
	assign gs_new = gs_ovf ? (gs_sum[GSUM_W] ? GSUM_MIN : GSUM_MAX) : gs_sum[GSUM_W-1:0];

	assign term     = prod2_s3 >>> SCALE_FRACTION_BITS;
	assign acc_sum  = (ACC_W+1)'(acc_q) + $signed(term[ACC_W:0]);
	assign acc_ovf  = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];
	assign acc_new  = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];
	assign acc_fire = v_s3 & ~stall;

	assign empty = ~out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q        <= '0;
			grp_clip_q  <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_data.closes) begin
					gs_q       <= '0;
					grp_clip_q <= 1'b0;
				end else begin
					gs_q       <= gs_new;
					grp_clip_q <= grp_clip_q | gs_ovf;
				end
			end
			if (!stall) begin
				v_s1 <= q_pop & q_data.closes;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (acc_fire) begin
				if (row_end_s3) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= acc_new;
					clip_q <= clip_q | clip_s3 | acc_ovf;
				end
			end
			if (acc_fire && row_end_s3) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			gsum_s1    <= gs_new;
			sa_s1      <= q_data.act_scale;
			sw_s1      <= q_data.weight_scale;
			row_end_s1 <= q_data.row_end;
			clip_s1    <= grp_clip_q | gs_ovf;

			prod1_s2   <= PROD1_W'(gsum_s1) * PROD1_W'(sa_s1);
			sw_s2      <= sw_s1;
			row_end_s2 <= row_end_s1;
			clip_s2    <= clip_s1;

			prod2_s3   <= PROD2_W'(prod1_s2) * PROD2_W'(sw_s2);
			row_end_s3 <= row_end_s2;
			clip_s3    <= clip_s2;
		end
		if (acc_fire && row_end_s3) begin
			row_value <= acc_new;
			saturated <= clip_q | clip_s3 | acc_ovf;
		end
	end

endmodule

@@ design/int4_packed_group_dot_row_core.sv @@
// Top level of the int8 x int4 group-quantized dot-product row core.
// Depends on i4dot_pkg, i4dot_front, i4dot_queue and i4dot_back.
//
// Each item carries one packed weight byte (low nibble = first half of the
// group, high nibble = second half) and the two int8 activations that pair
// with it. Items stream in at one per clock while full is low: the front
// end forms both signed nibble products and hands the item to a four-entry
// queue; the back end adds it into a 20-bit saturating group sum. An item
// with group_end or row_end closes the group: its sum goes through two
// registered multiplies (sum x act_scale, then x weight_scale, both Q4.12),
// is shifted right by 12 with rounding toward minus infinity, and is added
// into a 48-bit saturating row accumulator. Group closes do not hold up the
// stream: the multiplies run in their own stages behind the group sum. A
// row_end item gives one result (row_value, saturated) in the output
// register; other items give none. Sustained rate is one item per cycle
// unless the back end stalls, limited by the single group-sum adder. The
// result waits there; while it is not popped, the back end stalls only when
// the next row result reaches the accumulator; the queue then fills its four
// entries and the front register takes one more item before full rises.
module int4_packed_group_dot_row_core import i4dot_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [ACT_W-1:0]   act_low,
	input  logic signed [ACT_W-1:0]   act_high,
	input  logic [WBYTE_W-1:0]        weight_byte,
	input  logic signed [SCALE_W-1:0] act_scale,
	input  logic signed [SCALE_W-1:0] weight_scale,
	input  logic                      group_end,
	input  logic                      row_end,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [ACC_W-1:0]   row_value,
	output logic                      saturated
);

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	item_t q_wr_data;
	item_t q_rd_data;

	i4dot_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.act_low      (act_low),
		.act_high     (act_high),
		.weight_byte  (weight_byte),
		.act_scale    (act_scale),
		.weight_scale (weight_scale),
		.group_end    (group_end),
		.row_end      (row_end),
		.q_push       (q_push),
		.q_data       (q_wr_data),
		.q_full       (q_full)
	);

	i4dot_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.wr_data (q_wr_data),
		.q_full  (q_full),
		.q_pop   (q_pop),
		.rd_data (q_rd_data),
		.q_empty (q_empty)
	);

	i4dot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_rd_data),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.row_value (row_value),
		.saturated (saturated)
	);

	// the front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	// the back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	// full only drops after the back has read the queue
	a_full_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !q_pop) |=> full)
		else $error("full dropped without a queue read");

endmodule
